// ===== hw/rtl/gtre_pkg.sv =====
// Shared types and constants for the greedy tile rectangle encoder.
// Used by gtre_ctrl, gtre_dpath and greedy_tile_rectangle_encoder_top.
package gtre_pkg;

  localparam int COL_W    = 6;
  localparam int ROW_W    = 6;
  localparam int ADDR_W   = COL_W + ROW_W;
  localparam int CODE_W   = 16;
  localparam int CNT_W    = 7;
  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;
  localparam int DEPTH    = MAX_COLS * MAX_ROWS;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_NEXT  = 1'b1;

  typedef enum logic [0:0] {
    CFG_GRID_COLS = 1'b0,
    CFG_GRID_ROWS = 1'b1
  } cfg_idx_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_cell;    // store the cell of an accepted write request
    logic rd_scan;    // read the cell at the scan position
    logic scan_next;  // step the scan one column
    logic scan_wrap;  // scan to column 0 of the next row
    logic take_code;  // latch the found code, start the width run
    logic rd_xy;      // read the cell at the work position
    logic wid_inc;    // width grows by one
    logic row_init;   // work position to the rectangle's top left
    logic x_inc;      // next column of the row under test
    logic x_home;     // work column back to the left edge
    logic clr;        // clear the cell at the work position
    logic row_next;   // row covered: height grows, go one row down
    logic emit_rec;   // load the output register with a record
    logic emit_end;   // load the end marker and mark the scan done
    logic finish;     // advance the scan past the record's start
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;       // scan exhausted
    logic row_out;    // scan row outside the area
    logic col_out;    // scan column outside the area
    logic nz;         // read data is not empty
    logic match;      // read data equals the rectangle code
    logic x_out;      // work column outside the area
    logic y_out;      // work row outside the area
    logic x_last;     // work column is the rectangle's right edge
    logic out_busy;   // output register holds a stalled record
  } sts_t;

endpackage

// ===== hw/rtl/gtre_ctrl.sv =====
// Controller state machine of the greedy tile rectangle encoder.
// Depends on gtre_pkg; drives the datapath gtre_dpath through cmd_t.
module gtre_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_func,
  output logic          in_stall,
  input  gtre_pkg::sts_t sts,
  output gtre_pkg::cmd_t cmd
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_SCAN_RD  = 10'b0000000010,
    S_SCAN_CHK = 10'b0000000100,
    S_WID_RD   = 10'b0000001000,
    S_WID_CHK  = 10'b0000010000,
    S_ROW_RD   = 10'b0000100000,
    S_ROW_CHK  = 10'b0001000000,
    S_CLR      = 10'b0010000000,
    S_REC      = 10'b0100000000,
    S_END      = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_func == gtre_pkg::FUNC_WRITE) begin
            cmd.wr_cell = 1'b1;
          end else if (sts.done) begin
            state_nxt = S_END;
          end else begin
            state_nxt = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        if (sts.row_out) begin
          state_nxt = S_END;
        end else if (sts.col_out) begin
          cmd.scan_wrap = 1'b1;
        end else begin
          cmd.rd_scan = 1'b1;
          state_nxt   = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (sts.nz) begin
          cmd.take_code = 1'b1;
          state_nxt     = S_WID_RD;
        end else begin
          cmd.scan_next = 1'b1;
          state_nxt     = S_SCAN_RD;
        end
      end
      S_WID_RD: begin
        if (sts.x_out) begin
          cmd.row_init = 1'b1;
          state_nxt    = S_ROW_RD;
        end else begin
          cmd.rd_xy = 1'b1;
          state_nxt = S_WID_CHK;
        end
      end
      S_WID_CHK: begin
        if (sts.match) begin
          cmd.wid_inc = 1'b1;
          state_nxt   = S_WID_RD;
        end else begin
          cmd.row_init = 1'b1;
          state_nxt    = S_ROW_RD;
        end
      end
      S_ROW_RD: begin
        if (sts.y_out) begin
          state_nxt = S_REC;
        end else begin
          cmd.rd_xy = 1'b1;
          state_nxt = S_ROW_CHK;
        end
      end
      S_ROW_CHK: begin
        // A row is cleared only after every cell under the rectangle matched.
        if (!sts.match) begin
          state_nxt = S_REC;
        end else if (sts.x_last) begin
          cmd.x_home = 1'b1;
          state_nxt  = S_CLR;
        end else begin
          cmd.x_inc = 1'b1;
          state_nxt = S_ROW_RD;
        end
      end
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.x_last) begin
          cmd.row_next = 1'b1;
          state_nxt    = S_ROW_RD;
        end
      end
      S_REC: begin
        if (!sts.out_busy) begin
          cmd.emit_rec = 1'b1;
          cmd.finish   = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_END: begin
        if (!sts.out_busy) begin
          cmd.emit_end = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/gtre_dpath.sv =====
// Datapath of the greedy tile rectangle encoder: tile map memory, scan and
// work counters, configuration registers and the output register. Uses gtre_pkg.
module gtre_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gtre_pkg::cmd_t                cmd,
  output gtre_pkg::sts_t                sts,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [gtre_pkg::CNT_W-1:0]    cfg_wdata,
  input  logic [gtre_pkg::COL_W-1:0]    in_cell_col,
  input  logic [gtre_pkg::ROW_W-1:0]    in_cell_row,
  input  logic [gtre_pkg::CODE_W-1:0]   in_tile_code,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gtre_pkg::CODE_W-1:0]   out_rect_code,
  output logic [gtre_pkg::COL_W-1:0]    out_rect_col,
  output logic [gtre_pkg::ROW_W-1:0]    out_rect_row,
  output logic [gtre_pkg::CNT_W-1:0]    out_rect_width,
  output logic [gtre_pkg::CNT_W-1:0]    out_rect_height,
  output logic                          out_is_end
);

  localparam int CNT_W  = gtre_pkg::CNT_W;
  localparam int COL_W  = gtre_pkg::COL_W;
  localparam int ROW_W  = gtre_pkg::ROW_W;
  localparam int CODE_W = gtre_pkg::CODE_W;
  localparam int ADDR_W = gtre_pkg::ADDR_W;

  logic [CODE_W-1:0] mem [gtre_pkg::DEPTH];
  logic [CODE_W-1:0] rdata_r;
  logic [ADDR_W-1:0] raddr, waddr;
  logic [CODE_W-1:0] wdata;
  logic              we;

  logic [CNT_W-1:0] grid_cols_r, grid_rows_r;
  logic [CNT_W-1:0] cols_eff, rows_eff;
  logic [CNT_W-1:0] scan_c_r, scan_r_r, x_r, y_r, w_r, h_r;
  logic [CNT_W-1:0] scan_c_nxt, scan_r_nxt, x_nxt, y_nxt, w_nxt, h_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0] fin_c, fin_r;
  logic [CNT_W-1:0] right_edge;

  logic              out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0] o_code_r;
  logic [COL_W-1:0]  o_col_r;
  logic [ROW_W-1:0]  o_row_r;
  logic [CNT_W-1:0]  o_w_r, o_h_r;
  logic              o_end_r;

  // Settings above the storage size act as the storage size.
  assign cols_eff = (grid_cols_r > CNT_W'(gtre_pkg::MAX_COLS)) ?
                    CNT_W'(gtre_pkg::MAX_COLS) : grid_cols_r;
  assign rows_eff = (grid_rows_r > CNT_W'(gtre_pkg::MAX_ROWS)) ?
                    CNT_W'(gtre_pkg::MAX_ROWS) : grid_rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r <= CNT_W'(64);
      grid_rows_r <= CNT_W'(48);
    end else if (cfg_wr_en) begin
      unique case (gtre_pkg::cfg_idx_t'(cfg_index))
        gtre_pkg::CFG_GRID_COLS: grid_cols_r <= cfg_wdata;
        gtre_pkg::CFG_GRID_ROWS: grid_rows_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Tile map memory: one write and one registered read per cycle.
  assign raddr = cmd.rd_scan ? {scan_r_r[ROW_W-1:0], scan_c_r[COL_W-1:0]}
                             : {y_r[ROW_W-1:0], x_r[COL_W-1:0]};
  assign waddr = cmd.wr_cell ? {in_cell_row, in_cell_col}
                             : {y_r[ROW_W-1:0], x_r[COL_W-1:0]};
  assign wdata = cmd.wr_cell ? in_tile_code : '0;
  assign we    = cmd.wr_cell || cmd.clr;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_scan || cmd.rd_xy) begin
      rdata_r <= mem[raddr];
    end
  end

  assign right_edge = scan_c_r + w_r;
  assign fin_c      = scan_c_r + CNT_W'(1);
  assign fin_r      = scan_r_r + CNT_W'(1);

  always_comb begin
    scan_c_nxt = scan_c_r;
    scan_r_nxt = scan_r_r;
    done_nxt   = done_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    w_nxt      = w_r;
    h_nxt      = h_r;
    code_nxt   = code_r;
    if (cmd.wr_cell) begin
      scan_c_nxt = '0;
      scan_r_nxt = '0;
      done_nxt   = 1'b0;
    end
    if (cmd.scan_next) begin
      scan_c_nxt = fin_c;
    end
    if (cmd.scan_wrap) begin
      scan_c_nxt = '0;
      scan_r_nxt = fin_r;
    end
    if (cmd.take_code) begin
      code_nxt = rdata_r;
      x_nxt    = fin_c;
      y_nxt    = scan_r_r;
      w_nxt    = CNT_W'(1);
    end
    if (cmd.wid_inc) begin
      w_nxt = w_r + CNT_W'(1);
      x_nxt = x_r + CNT_W'(1);
    end
    if (cmd.row_init) begin
      x_nxt = scan_c_r;
      h_nxt = '0;
    end
    if (cmd.x_inc || cmd.clr) begin
      x_nxt = x_r + CNT_W'(1);
    end
    if (cmd.x_home) begin
      x_nxt = scan_c_r;
    end
    if (cmd.row_next) begin
      x_nxt = scan_c_r;
      y_nxt = y_r + CNT_W'(1);
      h_nxt = h_r + CNT_W'(1);
    end
    if (cmd.emit_end) begin
      done_nxt = 1'b1;
    end
    // After a record the scan resumes one cell past its start, wrapping rows.
    if (cmd.finish) begin
      if (fin_c >= cols_eff) begin
        scan_c_nxt = '0;
        scan_r_nxt = fin_r;
        done_nxt   = (fin_r >= rows_eff);
      end else begin
        scan_c_nxt = fin_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_c_r <= '0;
      scan_r_r <= '0;
      done_r   <= 1'b0;
    end else begin
      scan_c_r <= scan_c_nxt;
      scan_r_r <= scan_r_nxt;
      done_r   <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    w_r    <= w_nxt;
    h_r    <= h_nxt;
    code_r <= code_nxt;
  end

  assign sts.done     = done_r;
  assign sts.row_out  = (scan_r_r >= rows_eff);
  assign sts.col_out  = (scan_c_r >= cols_eff);
  assign sts.nz       = (rdata_r != '0);
  assign sts.match    = (rdata_r == code_r);
  assign sts.x_out    = (x_r >= cols_eff);
  assign sts.y_out    = (y_r >= rows_eff);
  assign sts.x_last   = ((x_r + CNT_W'(1)) == right_edge);
  assign sts.out_busy = out_valid_r && out_stall;

  // Output register: the controller only loads it once the previous
  // record has left or leaves in that cycle.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.emit_rec || cmd.emit_end) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_rec) begin
      o_code_r <= code_r;
      o_col_r  <= scan_c_r[COL_W-1:0];
      o_row_r  <= scan_r_r[ROW_W-1:0];
      o_w_r    <= w_r;
      o_h_r    <= h_r;
      o_end_r  <= 1'b0;
    end else if (cmd.emit_end) begin
      o_code_r <= '0;
      o_col_r  <= '0;
      o_row_r  <= '0;
      o_w_r    <= '0;
      o_h_r    <= '0;
      o_end_r  <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_rect_code   = o_code_r;
  assign out_rect_col    = o_col_r;
  assign out_rect_row    = o_row_r;
  assign out_rect_width  = o_w_r;
  assign out_rect_height = o_h_r;
  assign out_is_end      = o_end_r;

endmodule

// ===== hw/rtl/greedy_tile_rectangle_encoder_top.sv =====
// Greedy tile rectangle encoder. Cell writes are accepted back to back.
// A next request is accepted, then each cell is read (registered map read, then
// compare), covered cells are cleared one by one, scan row wraps and area edges are met,
// and the record is loaded; the input stalls until then, and loading waits while a record sits stalled.
// Synchronous active-low reset: scan at row 0 column 0, registers 64 and 48,
// the tile map itself is not cleared and its contents are undefined until written.
module greedy_tile_rectangle_encoder_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [gtre_pkg::CNT_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_func,
  input  logic [gtre_pkg::COL_W-1:0]    in_cell_col,
  input  logic [gtre_pkg::ROW_W-1:0]    in_cell_row,
  input  logic [gtre_pkg::CODE_W-1:0]   in_tile_code,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gtre_pkg::CODE_W-1:0]   out_rect_code,
  output logic [gtre_pkg::COL_W-1:0]    out_rect_col,
  output logic [gtre_pkg::ROW_W-1:0]    out_rect_row,
  output logic [gtre_pkg::CNT_W-1:0]    out_rect_width,
  output logic [gtre_pkg::CNT_W-1:0]    out_rect_height,
  output logic                          out_is_end
);

  gtre_pkg::cmd_t cmd;
  gtre_pkg::sts_t sts;

  gtre_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  gtre_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_cell_col     (in_cell_col),
    .in_cell_row     (in_cell_row),
    .in_tile_code    (in_tile_code),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_rect_code   (out_rect_code),
    .out_rect_col    (out_rect_col),
    .out_rect_row    (out_rect_row),
    .out_rect_width  (out_rect_width),
    .out_rect_height (out_rect_height),
    .out_is_end      (out_is_end)
  );

  // A next request keeps the input side busy until its record is loaded.
  a_next_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_func == gtre_pkg::FUNC_NEXT) |=> in_stall)
    else $error("input not stalled after a next request");

  // An end marker carries an all-zero record.
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_end) |->
      (out_rect_code == '0 && out_rect_width == '0 && out_rect_height == '0))
    else $error("end marker with nonzero record");

  // A real rectangle covers at least one cell of a non-empty code.
  a_rect_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_end) |->
      (out_rect_code != '0 && out_rect_width != '0 && out_rect_height != '0))
    else $error("empty rectangle returned");

  // Any cell write restarts the scan.
  a_write_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_cell |=> !sts.done)
    else $error("scan still done after a cell write");

endmodule
